/* src/frsm_pkg.sv */
// shared constants and types for the frame ring with sequence monitor
`default_nettype none

package frsm_pkg;

  // descriptor ring geometry
  localparam int RING_DEPTH = 16;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  // field widths
  localparam int OCC_W  = 5;
  localparam int SEQ_W  = 64;
  localparam int TS_W   = 64;
  localparam int SEED_W = 32;
  localparam int CNT_W  = 64;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [FILL_W-1:0] fill_t;

  // request from the monitor to the ring
  typedef struct packed {
    logic en;
    logic push;
  } ring_ctl_t;

  // ring status: ok is for the request presented now, fill and peak are current
  typedef struct packed {
    logic  ok;
    fill_t fill;
    fill_t peak;
  } ring_sts_t;

endpackage

`default_nettype wire

/* src/frsm_ring.sv */
// descriptor storage with head and tail pointers, fill and peak fill
`default_nettype none

module frsm_ring (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire frsm_pkg::ring_ctl_t           ctl,
  input  wire logic [frsm_pkg::SEQ_W-1:0]    wr_sequence,
  input  wire logic [frsm_pkg::TS_W-1:0]     wr_timestamp,
  input  wire logic [frsm_pkg::SEED_W-1:0]   wr_seed,
  output frsm_pkg::ring_sts_t                sts,
  output logic [frsm_pkg::SEQ_W-1:0]         rd_sequence,
  output logic [frsm_pkg::TS_W-1:0]          rd_timestamp,
  output logic [frsm_pkg::SEED_W-1:0]        rd_seed
);

  logic [frsm_pkg::SEQ_W-1:0]  slot_seq_r  [frsm_pkg::RING_DEPTH];
  logic [frsm_pkg::TS_W-1:0]   slot_ts_r   [frsm_pkg::RING_DEPTH];
  logic [frsm_pkg::SEED_W-1:0] slot_seed_r [frsm_pkg::RING_DEPTH];

  frsm_pkg::ptr_t  head_r, head_nxt;
  frsm_pkg::ptr_t  tail_r, tail_nxt;
  frsm_pkg::fill_t fill_r, fill_nxt;
  frsm_pkg::fill_t peak_r, peak_nxt;

  logic not_full;
  logic not_empty;
  logic do_write;
  logic do_read;

  assign not_full  = fill_r < frsm_pkg::FILL_W'(frsm_pkg::RING_DEPTH);
  assign not_empty = fill_r != '0;
  assign do_write  = ctl.en && ctl.push && not_full;
  assign do_read   = ctl.en && !ctl.push && not_empty;

  assign sts.ok   = ctl.push ? not_full : not_empty;
  assign sts.fill = fill_r;
  assign sts.peak = peak_r;

  // oldest entry, valid only when not empty
  assign rd_sequence  = slot_seq_r[head_r];
  assign rd_timestamp = slot_ts_r[head_r];
  assign rd_seed      = slot_seed_r[head_r];

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    peak_nxt = peak_r;
    if (do_write) begin
      tail_nxt = (tail_r == frsm_pkg::PTR_W'(frsm_pkg::RING_DEPTH - 1)) ? '0 :
                 tail_r + frsm_pkg::PTR_W'(1);
      fill_nxt = fill_r + frsm_pkg::FILL_W'(1);
      if (fill_nxt > peak_r) begin
        peak_nxt = fill_nxt;
      end
    end else if (do_read) begin
      head_nxt = (head_r == frsm_pkg::PTR_W'(frsm_pkg::RING_DEPTH - 1)) ? '0 :
                 head_r + frsm_pkg::PTR_W'(1);
      fill_nxt = fill_r - frsm_pkg::FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      peak_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      peak_r <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      slot_seq_r[tail_r]  <= wr_sequence;
      slot_ts_r[tail_r]   <= wr_timestamp;
      slot_seed_r[tail_r] <= wr_seed;
    end
  end

endmodule

`default_nettype wire

/* src/frame_ring_with_sequence_monitor_top.sv */
// top level: input register, descriptor ring, sequence and timestamp monitors
// flow: an accepted word is held in the input register, then its result is registered onto out_*
// throughput: one word per cycle while out_stall does not hold a result, the monitor state update is a single pass
// reset: synchronous active low; pointers, fill, peak, monitors and counters clear
// descriptor storage is not cleared, a pop only ever reads a pushed entry
`default_nettype none

module frame_ring_with_sequence_monitor_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_op,
  input  wire logic [frsm_pkg::SEQ_W-1:0]  in_sequence,
  input  wire logic [frsm_pkg::TS_W-1:0]   in_timestamp,
  input  wire logic [frsm_pkg::SEED_W-1:0] in_seed,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_ok,
  output logic [frsm_pkg::SEQ_W-1:0]       out_sequence,
  output logic [frsm_pkg::TS_W-1:0]        out_timestamp,
  output logic [frsm_pkg::SEED_W-1:0]      out_seed,
  output logic [frsm_pkg::OCC_W-1:0]       out_occupancy,
  output logic [frsm_pkg::OCC_W-1:0]       out_peak_occupancy,
  output logic [frsm_pkg::CNT_W-1:0]       out_pushed_total,
  output logic [frsm_pkg::CNT_W-1:0]       out_drop_total,
  output logic [frsm_pkg::CNT_W-1:0]       out_source_gap_total,
  output logic [frsm_pkg::CNT_W-1:0]       out_reorder_total,
  output logic [frsm_pkg::CNT_W-1:0]       out_time_regress_total,
  output logic [frsm_pkg::CNT_W-1:0]       out_consumer_gap_total
);

  // result of following one sequence number on one side
  typedef struct packed {
    logic                       seen;
    logic [frsm_pkg::SEQ_W-1:0] last;
    logic [frsm_pkg::CNT_W-1:0] gap_cnt;
    logic                       older;
  } trk_t;

  // first number is only recorded; a jump adds the missing count;
  // a number not above the last one keeps the last one and is flagged
  function automatic trk_t seq_follow(
    input logic                       seen,
    input logic [frsm_pkg::SEQ_W-1:0] last,
    input logic [frsm_pkg::SEQ_W-1:0] seq,
    input logic [frsm_pkg::CNT_W-1:0] gap_cnt
  );
    trk_t res;
    res.seen    = 1'b1;
    res.last    = last;
    res.gap_cnt = gap_cnt;
    res.older   = 1'b0;
    if (!seen) begin
      res.last = seq;
    end else if (seq > last) begin
      // difference of one adds zero
      res.gap_cnt = gap_cnt + (seq - last - frsm_pkg::SEQ_W'(1));
      res.last    = seq;
    end else begin
      res.older = 1'b1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------
  logic                        s1_valid_r, s1_valid_nxt;
  logic                        s1_op_r;
  logic [frsm_pkg::SEQ_W-1:0]  s1_seq_r;
  logic [frsm_pkg::TS_W-1:0]   s1_ts_r;
  logic [frsm_pkg::SEED_W-1:0] s1_seed_r;

  logic in_acc;
  logic adv;          // the held word is processed at this edge

  // process whenever the result register is empty or is being drained
  assign adv      = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_op;
      s1_seq_r  <= in_sequence;
      s1_ts_r   <= in_timestamp;
      s1_seed_r <= in_seed;
    end
  end

  // ---------------------------------------------------------------------
  // descriptor ring
  // ---------------------------------------------------------------------
  frsm_pkg::ring_ctl_t         ring_ctl;
  frsm_pkg::ring_sts_t         ring_sts;
  logic [frsm_pkg::SEQ_W-1:0]  rd_seq;
  logic [frsm_pkg::TS_W-1:0]   rd_ts;
  logic [frsm_pkg::SEED_W-1:0] rd_seed;

  assign ring_ctl.en   = adv;
  assign ring_ctl.push = (s1_op_r == frsm_pkg::OP_PUSH);

  frsm_ring u_ring (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ring_ctl),
    .wr_sequence  (s1_seq_r),
    .wr_timestamp (s1_ts_r),
    .wr_seed      (s1_seed_r),
    .sts          (ring_sts),
    .rd_sequence  (rd_seq),
    .rd_timestamp (rd_ts),
    .rd_seed      (rd_seed)
  );

  // ---------------------------------------------------------------------
  // monitor state and statistics
  // ---------------------------------------------------------------------
  logic                       src_seen_r, src_seen_nxt;
  logic [frsm_pkg::SEQ_W-1:0] src_last_r, src_last_nxt;
  logic                       con_seen_r, con_seen_nxt;
  logic [frsm_pkg::SEQ_W-1:0] con_last_r, con_last_nxt;
  logic                       time_seen_r, time_seen_nxt;
  logic [frsm_pkg::TS_W-1:0]  ts_high_r, ts_high_nxt;

  logic [frsm_pkg::CNT_W-1:0] pushed_cnt_r, pushed_cnt_nxt;
  logic [frsm_pkg::CNT_W-1:0] drop_cnt_r, drop_cnt_nxt;
  logic [frsm_pkg::CNT_W-1:0] src_gap_cnt_r, src_gap_cnt_nxt;
  logic [frsm_pkg::CNT_W-1:0] reorder_cnt_r, reorder_cnt_nxt;
  logic [frsm_pkg::CNT_W-1:0] tregress_cnt_r, tregress_cnt_nxt;
  logic [frsm_pkg::CNT_W-1:0] con_gap_cnt_r, con_gap_cnt_nxt;

  // result register for the per-word fields
  logic                        out_valid_r, out_valid_nxt;
  logic                        ok_r, ok_nxt;
  logic [frsm_pkg::SEQ_W-1:0]  oseq_r, oseq_nxt;
  logic [frsm_pkg::TS_W-1:0]   ots_r, ots_nxt;
  logic [frsm_pkg::SEED_W-1:0] oseed_r, oseed_nxt;

  trk_t src_trk;
  trk_t con_trk;
  logic is_push;
  logic is_pop;

  assign is_push = adv && (s1_op_r == frsm_pkg::OP_PUSH);
  assign is_pop  = adv && (s1_op_r == frsm_pkg::OP_POP);

  assign src_trk = seq_follow(src_seen_r, src_last_r, s1_seq_r, src_gap_cnt_r);
  assign con_trk = seq_follow(con_seen_r, con_last_r, rd_seq, con_gap_cnt_r);

  always_comb begin
    src_seen_nxt     = src_seen_r;
    src_last_nxt     = src_last_r;
    con_seen_nxt     = con_seen_r;
    con_last_nxt     = con_last_r;
    time_seen_nxt    = time_seen_r;
    ts_high_nxt      = ts_high_r;
    pushed_cnt_nxt   = pushed_cnt_r;
    drop_cnt_nxt     = drop_cnt_r;
    src_gap_cnt_nxt  = src_gap_cnt_r;
    reorder_cnt_nxt  = reorder_cnt_r;
    tregress_cnt_nxt = tregress_cnt_r;
    con_gap_cnt_nxt  = con_gap_cnt_r;

    out_valid_nxt = out_valid_r;
    ok_nxt        = ok_r;
    oseq_nxt      = oseq_r;
    ots_nxt       = ots_r;
    oseed_nxt     = oseed_r;

    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (adv) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = ring_sts.ok;
      oseq_nxt      = '0;
      ots_nxt       = '0;
      oseed_nxt     = '0;
    end

    if (is_push) begin
      // monitors run even when the push is dropped
      src_seen_nxt    = src_trk.seen;
      src_last_nxt    = src_trk.last;
      src_gap_cnt_nxt = src_trk.gap_cnt;
      if (src_trk.older) begin
        reorder_cnt_nxt = reorder_cnt_r + frsm_pkg::CNT_W'(1);
      end
      // equal timestamp is neither a regression nor a new high
      if (time_seen_r && (s1_ts_r < ts_high_r)) begin
        tregress_cnt_nxt = tregress_cnt_r + frsm_pkg::CNT_W'(1);
      end
      if (!time_seen_r || (s1_ts_r > ts_high_r)) begin
        ts_high_nxt = s1_ts_r;
      end
      time_seen_nxt = 1'b1;
      if (ring_sts.ok) begin
        pushed_cnt_nxt = pushed_cnt_r + frsm_pkg::CNT_W'(1);
      end else begin
        drop_cnt_nxt = drop_cnt_r + frsm_pkg::CNT_W'(1);
      end
    end

    if (is_pop && ring_sts.ok) begin
      oseq_nxt        = rd_seq;
      ots_nxt         = rd_ts;
      oseed_nxt       = rd_seed;
      // an older number on the pop side is simply ignored
      con_seen_nxt    = con_trk.seen;
      con_last_nxt    = con_trk.last;
      con_gap_cnt_nxt = con_trk.gap_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_seen_r     <= 1'b0;
      src_last_r     <= '0;
      con_seen_r     <= 1'b0;
      con_last_r     <= '0;
      time_seen_r    <= 1'b0;
      ts_high_r      <= '0;
      pushed_cnt_r   <= '0;
      drop_cnt_r     <= '0;
      src_gap_cnt_r  <= '0;
      reorder_cnt_r  <= '0;
      tregress_cnt_r <= '0;
      con_gap_cnt_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      src_seen_r     <= src_seen_nxt;
      src_last_r     <= src_last_nxt;
      con_seen_r     <= con_seen_nxt;
      con_last_r     <= con_last_nxt;
      time_seen_r    <= time_seen_nxt;
      ts_high_r      <= ts_high_nxt;
      pushed_cnt_r   <= pushed_cnt_nxt;
      drop_cnt_r     <= drop_cnt_nxt;
      src_gap_cnt_r  <= src_gap_cnt_nxt;
      reorder_cnt_r  <= reorder_cnt_nxt;
      tregress_cnt_r <= tregress_cnt_nxt;
      con_gap_cnt_r  <= con_gap_cnt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    oseq_r  <= oseq_nxt;
    ots_r   <= ots_nxt;
    oseed_r <= oseed_nxt;
  end

  // ---------------------------------------------------------------------
  // outputs
  // ---------------------------------------------------------------------
  // state only moves when a word is processed, which never happens while a
  // result is held, so the statistics can be shown straight from state
  assign out_valid              = out_valid_r;
  assign out_ok                 = ok_r;
  assign out_sequence           = oseq_r;
  assign out_timestamp          = ots_r;
  assign out_seed               = oseed_r;
  assign out_occupancy          = frsm_pkg::OCC_W'(ring_sts.fill);
  assign out_peak_occupancy     = frsm_pkg::OCC_W'(ring_sts.peak);
  assign out_pushed_total       = pushed_cnt_r;
  assign out_drop_total         = drop_cnt_r;
  assign out_source_gap_total   = src_gap_cnt_r;
  assign out_reorder_total      = reorder_cnt_r;
  assign out_time_regress_total = tregress_cnt_r;
  assign out_consumer_gap_total = con_gap_cnt_r;

endmodule

`default_nettype wire

/* src/frsm_checker.sv */
// port level checks for the frame ring with sequence monitor, with its bind
`default_nettype none

module frsm_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic                        out_ok,
  input wire logic [frsm_pkg::SEQ_W-1:0]  out_sequence,
  input wire logic [frsm_pkg::TS_W-1:0]   out_timestamp,
  input wire logic [frsm_pkg::SEED_W-1:0] out_seed,
  input wire logic [frsm_pkg::OCC_W-1:0]  out_occupancy,
  input wire logic [frsm_pkg::OCC_W-1:0]  out_peak_occupancy
);

  // peak of the last word taken on the result side
  logic [frsm_pkg::OCC_W-1:0] last_peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_peak_r <= '0;
    end else if (out_valid && !out_stall) begin
      last_peak_r <= out_peak_occupancy;
    end
  end

  // a held result keeps its word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok) &&
      $stable(out_sequence) && $stable(out_timestamp) && $stable(out_seed))
    else $error("held result word changed");

  // a failed operation carries an all zero descriptor
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_sequence == '0 && out_timestamp == '0 &&
      out_seed == '0)
    else $error("failed operation shows a descriptor");

  // peak covers occupancy and occupancy stays within the ring
  a_peak_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_occupancy >= out_occupancy &&
      out_occupancy <= frsm_pkg::OCC_W'(frsm_pkg::RING_DEPTH))
    else $error("occupancy above peak or ring depth");

  // peak never falls from one result word to the next
  a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_occupancy >= last_peak_r)
    else $error("peak occupancy decreased");

endmodule

bind frame_ring_with_sequence_monitor_top frsm_checker u_frsm_checker (.*);

`default_nettype wire

/* tb/tb_frame_ring_with_sequence_monitor_top.sv */
// testbench for the frame descriptor ring with source, consumer and timestamp monitors
`timescale 1ns / 100ps

module tb_frame_ring_with_sequence_monitor_top;

  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned RANDOM_WORDS = 600;  // per idling phase

  // one expected or observed result word
  typedef struct {
    logic                        ok;
    logic [frsm_pkg::SEQ_W-1:0]  frame_seq;
    logic [frsm_pkg::TS_W-1:0]   frame_ts;
    logic [frsm_pkg::SEED_W-1:0] frame_seed;
    logic [frsm_pkg::OCC_W-1:0]  occupancy;
    logic [frsm_pkg::OCC_W-1:0]  peak_occupancy;
    logic [frsm_pkg::CNT_W-1:0]  pushed;
    logic [frsm_pkg::CNT_W-1:0]  drops;
    logic [frsm_pkg::CNT_W-1:0]  src_gaps;
    logic [frsm_pkg::CNT_W-1:0]  reorders;
    logic [frsm_pkg::CNT_W-1:0]  regressions;
    logic [frsm_pkg::CNT_W-1:0]  con_gaps;
  } ring_result_t;

  // ring and monitor mirror plus the queue of results still owed by the block
  class ring_ledger;
    logic [frsm_pkg::SEQ_W-1:0]  slot_seq  [frsm_pkg::RING_DEPTH];
    logic [frsm_pkg::TS_W-1:0]   slot_ts   [frsm_pkg::RING_DEPTH];
    logic [frsm_pkg::SEED_W-1:0] slot_seed [frsm_pkg::RING_DEPTH];
    int unsigned                 rd_idx, wr_idx, fill, peak;
    bit                          src_seen, con_seen, ts_seen;
    logic [frsm_pkg::SEQ_W-1:0]  last_src, last_con;
    logic [frsm_pkg::TS_W-1:0]   top_ts;
    logic [frsm_pkg::CNT_W-1:0]  n_pushed, n_drop, n_src_gap;
    logic [frsm_pkg::CNT_W-1:0]  n_reorder, n_regress, n_con_gap;
    ring_result_t                owed_results[$];
    int unsigned                 mismatches;

    function new();
      rd_idx = 0; wr_idx = 0; fill = 0; peak = 0;
      src_seen = 0; con_seen = 0; ts_seen = 0;
      last_src = '0; last_con = '0; top_ts = '0;
      n_pushed = '0; n_drop = '0; n_src_gap = '0;
      n_reorder = '0; n_regress = '0; n_con_gap = '0;
      mismatches = 0;
    endfunction

    function void take_word(logic op, logic [frsm_pkg::SEQ_W-1:0] seq,
                            logic [frsm_pkg::TS_W-1:0] ts,
                            logic [frsm_pkg::SEED_W-1:0] seed);
      ring_result_t r;
      r = '{default: '0};
      if (op == frsm_pkg::OP_PUSH) begin
        // source side: first one only recorded, lower or equal is a reorder
        if (!src_seen) begin
          src_seen = 1;
          last_src = seq;
        end else if (seq > last_src) begin
          n_src_gap += seq - last_src - 1;
          last_src = seq;
        end else begin
          n_reorder += 1;
        end
        if (ts_seen && ts < top_ts) n_regress += 1;
        if (!ts_seen || ts > top_ts) top_ts = ts;
        ts_seen = 1;
        // monitors update even when the word is dropped
        if (fill >= frsm_pkg::RING_DEPTH) begin
          n_drop += 1;
        end else begin
          slot_seq[wr_idx]  = seq;
          slot_ts[wr_idx]   = ts;
          slot_seed[wr_idx] = seed;
          wr_idx = (wr_idx + 1) % frsm_pkg::RING_DEPTH;
          fill++;
          n_pushed += 1;
          if (fill > peak) peak = fill;
          r.ok = 1'b1;
        end
      end else if (fill != 0) begin
        r.frame_seq  = slot_seq[rd_idx];
        r.frame_ts   = slot_ts[rd_idx];
        r.frame_seed = slot_seed[rd_idx];
        // consumer side counts gaps only, never reorders
        if (!con_seen) begin
          con_seen = 1;
          last_con = r.frame_seq;
        end else if (r.frame_seq > last_con) begin
          n_con_gap += r.frame_seq - last_con - 1;
          last_con = r.frame_seq;
        end
        rd_idx = (rd_idx + 1) % frsm_pkg::RING_DEPTH;
        fill--;
        r.ok = 1'b1;
      end
      r.occupancy      = frsm_pkg::OCC_W'(fill);
      r.peak_occupancy = frsm_pkg::OCC_W'(peak);
      r.pushed         = n_pushed;
      r.drops          = n_drop;
      r.src_gaps       = n_src_gap;
      r.reorders       = n_reorder;
      r.regressions    = n_regress;
      r.con_gaps       = n_con_gap;
      owed_results.push_back(r);
    endfunction

    function void compare(string what, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        mismatches++;
        $display("%0t %s expected %h actual %h", $time, what, want, seen);
      end
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        $display("%0t result word expected none actual ok=%b occupancy=%0d",
                 $time, got.ok, got.occupancy);
        return;
      end
      want = owed_results.pop_front();
      compare("ok", want.ok, got.ok);
      compare("sequence", want.frame_seq, got.frame_seq);
      compare("timestamp", want.frame_ts, got.frame_ts);
      compare("seed", want.frame_seed, got.frame_seed);
      compare("occupancy", want.occupancy, got.occupancy);
      compare("peak_occupancy", want.peak_occupancy, got.peak_occupancy);
      compare("pushed_total", want.pushed, got.pushed);
      compare("drop_total", want.drops, got.drops);
      compare("source_gap_total", want.src_gaps, got.src_gaps);
      compare("reorder_total", want.reorders, got.reorders);
      compare("time_regress_total", want.regressions, got.regressions);
      compare("consumer_gap_total", want.con_gaps, got.con_gaps);
    endfunction
  endclass

  // clock and reset, every input known from time zero
  logic                        clk;
  logic                        rst_n        = 1'b0;
  logic                        in_valid     = 1'b0;
  logic                        in_op        = frsm_pkg::OP_PUSH;
  logic [frsm_pkg::SEQ_W-1:0]  in_sequence  = '0;
  logic [frsm_pkg::TS_W-1:0]   in_timestamp = '0;
  logic [frsm_pkg::SEED_W-1:0] in_seed      = '0;
  logic                        out_stall    = 1'b0;

  logic                        in_stall;
  logic                        out_valid;
  logic                        out_ok;
  logic [frsm_pkg::SEQ_W-1:0]  out_sequence;
  logic [frsm_pkg::TS_W-1:0]   out_timestamp;
  logic [frsm_pkg::SEED_W-1:0] out_seed;
  logic [frsm_pkg::OCC_W-1:0]  out_occupancy;
  logic [frsm_pkg::OCC_W-1:0]  out_peak_occupancy;
  logic [frsm_pkg::CNT_W-1:0]  out_pushed_total;
  logic [frsm_pkg::CNT_W-1:0]  out_drop_total;
  logic [frsm_pkg::CNT_W-1:0]  out_source_gap_total;
  logic [frsm_pkg::CNT_W-1:0]  out_reorder_total;
  logic [frsm_pkg::CNT_W-1:0]  out_time_regress_total;
  logic [frsm_pkg::CNT_W-1:0]  out_consumer_gap_total;

  // idling percentages, changed between phases
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  // stimulus stream state: next in-order sequence and highest timestamp sent
  logic [frsm_pkg::SEQ_W-1:0] src_next;
  logic [frsm_pkg::TS_W-1:0]  ts_now;

  ring_ledger ledger = new();

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  frame_ring_with_sequence_monitor_top u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_op                  (in_op),
    .in_sequence            (in_sequence),
    .in_timestamp           (in_timestamp),
    .in_seed                (in_seed),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_ok                 (out_ok),
    .out_sequence           (out_sequence),
    .out_timestamp          (out_timestamp),
    .out_seed               (out_seed),
    .out_occupancy          (out_occupancy),
    .out_peak_occupancy     (out_peak_occupancy),
    .out_pushed_total       (out_pushed_total),
    .out_drop_total         (out_drop_total),
    .out_source_gap_total   (out_source_gap_total),
    .out_reorder_total      (out_reorder_total),
    .out_time_regress_total (out_time_regress_total),
    .out_consumer_gap_total (out_consumer_gap_total)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // handshake monitor: values seen here are the ones present before the edge
  always @(posedge clk) begin
    ring_result_t seen;
    if (rst_n) begin
      // note the accepted word first so a same-edge result finds its expectation
      if (in_valid && !in_stall)
        ledger.take_word(in_op, in_sequence, in_timestamp, in_seed);
      if (out_valid && !out_stall) begin
        seen.ok             = out_ok;
        seen.frame_seq      = out_sequence;
        seen.frame_ts       = out_timestamp;
        seen.frame_seed     = out_seed;
        seen.occupancy      = out_occupancy;
        seen.peak_occupancy = out_peak_occupancy;
        seen.pushed         = out_pushed_total;
        seen.drops          = out_drop_total;
        seen.src_gaps       = out_source_gap_total;
        seen.reorders       = out_reorder_total;
        seen.regressions    = out_time_regress_total;
        seen.con_gaps       = out_consumer_gap_total;
        ledger.check_result(seen);
      end
    end
  end

  // watchdog: a run that reaches the limit has hung
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // present one word, optionally after idle cycles, and hold it until taken
  task automatic send_word(input logic op, input logic [frsm_pkg::SEQ_W-1:0] seq,
                           input logic [frsm_pkg::TS_W-1:0] ts,
                           input logic [frsm_pkg::SEED_W-1:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_sequence  <= seq;
    in_timestamp <= ts;
    in_seed      <= seed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic push_frame(input logic [frsm_pkg::SEQ_W-1:0] seq,
                            input logic [frsm_pkg::TS_W-1:0] ts,
                            input logic [frsm_pkg::SEED_W-1:0] seed);
    send_word(frsm_pkg::OP_PUSH, seq, ts, seed);
  endtask

  // pop carries random junk on the descriptor fields, which the block ignores
  task automatic pop_frame();
    send_word(frsm_pkg::OP_POP, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
  endtask

  // mostly in-order frames with random content, some gaps, reorders and regressions
  task automatic random_words(input int unsigned count);
    logic [frsm_pkg::SEQ_W-1:0] seq;
    logic [frsm_pkg::TS_W-1:0]  ts;
    int unsigned                push_pct;
    int unsigned                pick;
    push_pct = 50;
    for (int unsigned i = 0; i < count; i++) begin
      // bursts that lean to push or pop drive the ring to full and to empty
      if (i % 24 == 0) begin
        pick = $urandom_range(2);
        push_pct = (pick == 0) ? 85 : (pick == 1) ? 20 : 50;
      end
      if ($urandom_range(99) < push_pct) begin
        pick = $urandom_range(99);
        if (pick < 78)
          seq = src_next;
        else if (pick < 88)
          seq = src_next + $urandom_range(1, 5);
        else
          seq = {1'b0, 31'($urandom), $urandom};  // always below the stream
        if (seq >= src_next) src_next = seq + 1;
        pick = $urandom_range(99);
        if (pick < 70)
          ts = ts_now + $urandom_range(1, 1000);
        else if (pick < 85)
          ts = ts_now;
        else
          ts = {1'b0, 31'($urandom), $urandom};
        if (ts > ts_now) ts_now = ts;
        push_frame(seq, ts, $urandom);
      end else begin
        pop_frame();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: sender idles a little, receiver a lot
    send_idle_pct  = 13;
    recv_stall_pct = 57;
    pop_frame();                                  // pop on an empty ring
    push_frame(64'd0, 64'd0, 32'h0000_0000);      // first sequence, first timestamp
    push_frame(64'd1, 64'd0, 32'hFFFF_FFFF);      // adjacent sequence, equal timestamp
    push_frame(64'd1, 64'd100, 32'h1234_5678);    // duplicate sequence
    push_frame(64'd0, 64'd50, 32'h8765_4321);     // lower sequence, timestamp regression
    push_frame(64'd9, 64'd100, 32'h0F0F_0F0F);    // gap of seven, equal timestamp
    push_frame(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 32'h5A5A_5A5A);
    repeat (6) pop_frame();                       // consumer: first, adjacent, equal, lower, gaps
    pop_frame();                                  // empty again

    // random stream picks up above the directed sequences and timestamps
    src_next = 64'h8000_0000_0000_0001;
    ts_now   = 64'h8000_0000_0000_0000;
    random_words(RANDOM_WORDS);

    // swap idling sides
    send_idle_pct  = 57;
    recv_stall_pct = 13;
    random_words(RANDOM_WORDS);

    // full rate both ways
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_words(RANDOM_WORDS);

    // close with the all-ones descriptor and drain the ring past empty
    repeat (frsm_pkg::RING_DEPTH + 1) pop_frame();
    push_frame('1, '1, '1);
    pop_frame();
    pop_frame();
    in_valid <= 1'b0;

    while (ledger.owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (ledger.owed_results.size() != 0) ledger.mismatches++;

    if (ledger.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/frsm_pkg.sv
src/frsm_ring.sv
src/frame_ring_with_sequence_monitor_top.sv
src/frsm_checker.sv
tb/tb_frame_ring_with_sequence_monitor_top.sv
